// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the voice allocator RTL.
// Needs nothing else; each file that asserts includes it in its module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pva_pkg.sv -----
// Types, codes and constants of the polyphonic voice allocator.
// Used by pva_ctrl, pva_dp and poly_voice_allocator_top; depends on nothing.
package pva_pkg;

    localparam int DEF_VOICES = 16;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 8;
    localparam int VIDX_W     = 4;
    localparam int MASK_W     = 16;
    localparam int CNT_W      = 5;
    localparam int POLY_W     = 5;
    localparam int AGE_W      = 32;
    localparam int PREV_W     = 8;

    localparam logic [POLY_W-1:0]        POLY_RESET = 5'd16;
    localparam logic signed [PREV_W-1:0] LAST_NONE  = -8'sd1;

    typedef enum logic [1:0] {
        CMD_NOTE_ON    = 2'd0,
        CMD_NOTE_OFF   = 2'd1,
        CMD_PANIC      = 2'd2,
        CMD_VOICE_DONE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   velocity;
        logic [VIDX_W-1:0]  done_voice;
    } t_req;

    typedef struct packed {
        logic                      start_valid;
        logic [VIDX_W-1:0]         start_voice;
        logic [NOTE_W-1:0]         start_note;
        logic [VEL_W-1:0]          start_velocity;
        logic signed [PREV_W-1:0]  previous_note;
        logic                      kill_valid;
        logic [VIDX_W-1:0]         kill_voice;
        logic [MASK_W-1:0]         release_mask;
        logic [MASK_W-1:0]         active_mask;
        logic [CNT_W-1:0]          active_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_APPLY,
        S_REPORT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic lookup;
        logic scan;
        logic apply;
        logic report;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_note_on;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/pva_ctrl.sv -----
// Sequencing state machine of the voice allocator.
// Depends on pva_pkg and assert_macros.svh; drives pva_dp through t_dp_cmd.
module pva_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pva_pkg::t_dp_stat i_stat,
    output pva_pkg::t_dp_cmd  o_cmd
);
    import pva_pkg::*;
    `include "assert_macros.svh"

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_stat.is_note_on ? S_SCAN : S_APPLY;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_REPORT;
            end
            S_REPORT: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPLY(a_report_free, i_clk, i_rst_n, o_cmd.report, i_stat.out_free,
                  "result loaded while output register busy")
    `ASSERT_NEXT(a_accept_lookup, i_clk, i_rst_n, i_in_valid && o_in_ready,
                 r_state == S_LOOKUP, "accepted request not decoded next cycle")

endmodule

// ----- hw/rtl/pva_dp.sv -----
// Voice pool datapath: voice state, lookup, age scan, update and result register.
// Depends on pva_pkg and assert_macros.svh; sequenced by pva_ctrl.
module pva_dp #(
    parameter int VOICES = pva_pkg::DEF_VOICES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pva_pkg::t_req               i_req,
    input  logic                        i_cfg_we,
    input  logic [pva_pkg::POLY_W-1:0]  i_cfg_data,
    input  pva_pkg::t_dp_cmd            i_cmd,
    output pva_pkg::t_dp_stat           o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pva_pkg::t_rsp               o_out
);
    import pva_pkg::*;
    `include "assert_macros.svh"

    localparam int IW  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW  = $clog2(VOICES + 1);
    localparam int PW  = (CW > POLY_W) ? CW : POLY_W;

    // voice pool
    logic [VOICES-1:0]  r_active;
    logic [VOICES-1:0]  r_gated;
    logic [NOTE_W-1:0]  r_note [VOICES];
    logic [AGE_W-1:0]   r_age  [VOICES];
    logic [AGE_W-1:0]   r_age_cnt;
    logic [PREV_W-1:0]  r_last;
    logic [POLY_W-1:0]  r_max_poly;

    // request and working registers
    t_req               r_req;
    logic [IW-1:0]      r_v;
    logic               r_v_known;
    logic [CW-1:0]      r_others;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_best;
    logic               r_best_ok;
    logic [AGE_W-1:0]   r_best_age;
    logic [IW-1:0]      r_second;
    logic               r_second_ok;
    logic [AGE_W-1:0]   r_second_age;
    logic [IW-1:0]      r_start_voice;
    logic               r_kill_valid;
    logic [IW-1:0]      r_kill_voice;
    logic [VOICES-1:0]  r_rel_mask;
    logic [PREV_W-1:0]  r_prev;
    logic               r_out_valid;
    t_rsp               r_out;

    logic               is_on;
    logic               hit_found, free_found;
    logic [IW-1:0]      hit_idx, free_idx;
    logic [CW-1:0]      act_cnt;
    logic               scan_elig;
    logic [AGE_W-1:0]   scan_age;
    logic [IW-1:0]      v_fin, oldest;
    logic               oldest_ok;
    logic [PW-1:0]      cfg_x, poly;
    logic               kill;
    logic [VOICES-1:0]  off_mask;
    logic               done_ok;
    logic [IW-1:0]      done_idx;

    assign is_on = (r_req.command == CMD_NOTE_ON);

    // first active voice on the note, first free voice, pool count, gated voices on the note
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        act_cnt    = '0;
        off_mask   = '0;
        for (int i = 0; i < VOICES; i++) begin
            if (!hit_found && r_active[i] && r_note[i] == r_req.note) begin
                hit_found = 1'b1;
                hit_idx   = IW'(i);
            end
            if (!free_found && !r_active[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
            if (r_active[i]) begin
                act_cnt = act_cnt + CW'(1);
            end
            off_mask[i] = r_active[i] && r_gated[i] && r_note[i] == r_req.note;
        end
    end

    assign scan_age  = r_age[r_idx];
    assign scan_elig = r_active[r_idx] && !(r_v_known && r_idx == r_v);

    // with no hit or free voice the oldest is taken, the next oldest killed at the poly limit
    assign v_fin     = r_v_known ? r_v : r_best;
    assign oldest    = r_v_known ? r_best : r_second;
    assign oldest_ok = r_v_known ? r_best_ok : r_second_ok;

    always_comb begin
        cfg_x = PW'(r_max_poly);
        if (cfg_x == '0) begin
            poly = PW'(1);
        end else if (cfg_x > PW'(VOICES)) begin
            poly = PW'(VOICES);
        end else begin
            poly = cfg_x;
        end
    end

    assign kill     = (PW'(r_others) >= poly) && oldest_ok;
    assign done_ok  = (32'(r_req.done_voice) < VOICES);
    assign done_idx = IW'(r_req.done_voice);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_gated     <= '0;
            r_age_cnt   <= '0;
            r_last      <= LAST_NONE;
            r_max_poly  <= POLY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_poly <= i_cfg_data;
            end
            if (i_cmd.apply) begin
                unique case (r_req.command)
                    CMD_NOTE_ON: begin
                        if (kill) begin
                            r_active[oldest] <= 1'b0;
                            r_gated[oldest]  <= 1'b0;
                        end
                        r_active[v_fin] <= 1'b1;
                        r_gated[v_fin]  <= 1'b1;
                        r_age_cnt       <= r_age_cnt + AGE_W'(1);
                        r_last          <= PREV_W'(r_req.note);
                    end
                    CMD_NOTE_OFF: begin
                        r_gated <= r_gated & ~off_mask;
                    end
                    CMD_PANIC: begin
                        r_active <= '0;
                        r_gated  <= '0;
                    end
                    CMD_VOICE_DONE: begin
                        if (done_ok && r_active[done_idx] && !r_gated[done_idx]) begin
                            r_active[done_idx] <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.report) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        if (i_cmd.lookup) begin
            r_v         <= hit_found ? hit_idx : free_idx;
            r_v_known   <= hit_found || free_found;
            r_others    <= act_cnt - ((hit_found || !free_found) ? CW'(1) : CW'(0));
            r_idx       <= '0;
            r_best_ok   <= 1'b0;
            r_second_ok <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + IW'(1);
            if (scan_elig) begin
                if (!r_best_ok || scan_age < r_best_age) begin
                    // demote the current best to runner-up
                    r_second     <= r_best;
                    r_second_ok  <= r_best_ok;
                    r_second_age <= r_best_age;
                    r_best       <= r_idx;
                    r_best_ok    <= 1'b1;
                    r_best_age   <= scan_age;
                end else if (!r_second_ok || scan_age < r_second_age) begin
                    r_second     <= r_idx;
                    r_second_ok  <= 1'b1;
                    r_second_age <= scan_age;
                end
            end
        end
        if (i_cmd.apply) begin
            r_start_voice <= v_fin;
            r_kill_valid  <= is_on && kill;
            r_kill_voice  <= oldest;
            r_rel_mask    <= (r_req.command == CMD_NOTE_OFF) ? off_mask : '0;
            r_prev        <= r_last;
            if (is_on) begin
                r_note[v_fin] <= r_req.note;
                r_age[v_fin]  <= r_age_cnt;
            end
        end
        if (i_cmd.report) begin
            r_out.start_valid    <= is_on;
            r_out.start_voice    <= is_on ? VIDX_W'(r_start_voice) : '0;
            r_out.start_note     <= is_on ? r_req.note : '0;
            r_out.start_velocity <= is_on ? r_req.velocity : '0;
            r_out.previous_note  <= is_on ? r_prev : '0;
            r_out.kill_valid     <= r_kill_valid;
            r_out.kill_voice     <= r_kill_valid ? VIDX_W'(r_kill_voice) : '0;
            r_out.release_mask   <= MASK_W'(r_rel_mask);
            r_out.active_mask    <= MASK_W'(r_active);
            r_out.active_count   <= CNT_W'(act_cnt);
        end
    end

    assign o_stat.is_note_on = is_on;
    assign o_stat.scan_last  = (r_idx == IW'(VOICES - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    `ASSERT_IMPLY(a_kill_not_start, i_clk, i_rst_n, i_cmd.apply && is_on && kill,
                  oldest != v_fin, "killed voice equals started voice")
    `ASSERT_NEXT(a_start_active, i_clk, i_rst_n, i_cmd.apply && is_on,
                 r_active[$past(v_fin)], "started voice not active after update")

endmodule

// ----- hw/rtl/poly_voice_allocator_top.sv -----
// Top level of the polyphonic voice allocator: controller plus datapath.
// Depends on pva_pkg, pva_ctrl and pva_dp.
//
//  channel  direction  handshake                  payload
//  request  in         i_in_valid / o_in_ready    i_in  (t_req)
//  result   out        o_out_valid / i_out_ready  o_out (t_rsp)
//  config   in         i_cfg_we                   i_cfg_data (max polyphony)
//
// A note on goes from accept through lookup, the age scan, update and report:
// the age compare unit scans one voice per cycle for the oldest and next
// oldest. Note off, panic and voice done skip the scan. One request is in
// work at a time; a new one is taken while the previous result waits in the
// output register, and a stalled output holds the next result in its report
// state. Reset is synchronous, active low, and clears the pool at once.
module poly_voice_allocator_top #(
    parameter int VOICES = pva_pkg::DEF_VOICES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pva_pkg::t_req               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pva_pkg::t_rsp               o_out,
    input  logic                        i_cfg_we,
    input  logic [pva_pkg::POLY_W-1:0]  i_cfg_data
);
    import pva_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    pva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    pva_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
